/* sv/dmcl_pkg.sv */
// Package for the direct-mapped cache lookup block.
// Holds the request and result payload types and fixed field constants.
// No dependencies.
package dmcl_pkg;

    // Fixed field widths
    localparam int ADDR_BITS   = 32;
    localparam int WORD_BITS   = 32;
    localparam int BYTE_BITS   = 8;
    localparam int COUNT_BITS  = 32;
    localparam int OFFSET_BITS = 2;

    // Epoch marks: value zero tags a line that holds nothing
    localparam int EPOCH_BITS = 8;
    localparam logic [EPOCH_BITS-1:0] EPOCH_NONE  = '0;
    localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = {{(EPOCH_BITS-1){1'b0}}, 1'b1};
    localparam logic [EPOCH_BITS-1:0] EPOCH_LAST  = '1;

    // Request kinds
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_INVAL = 1'b1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic                 kind;
        logic [ADDR_BITS-1:0] address;
        logic [WORD_BITS-1:0] fill_word;
    } t_req;

    typedef struct packed {
        logic [BYTE_BITS-1:0]  data_byte;
        logic                  was_hit;
        logic [COUNT_BITS-1:0] hit_total;
        logic [COUNT_BITS-1:0] miss_total;
    } t_rsp;

endpackage

/* sv/direct_mapped_cache_lookup_top.sv */
// Top level of the direct-mapped cache lookup block (4-byte lines).
// Depends on dmcl_pkg and dmcl_line_ram.
//
//   channel   direction  handshake                  payload
//   request   in         i_req_valid / o_req_ready  i_req (dmcl_pkg::t_req)
//   result    out        o_rsp_valid / i_rsp_ready  o_rsp (dmcl_pkg::t_rsp)
//
// One request per cycle sustained while o_req_ready is not held low by a sweep, a wrap or a
// stalled result; a result shows on o_rsp_valid once its request has passed the line store
// read into the request stage and then the tag compare into the result register.
// After reset the block sweeps every line with o_req_ready low.
// Invalidates bump an epoch mark; every 255th invalidate wraps it and starts the same
// sweep. A stalled result holds the compare stage, which then holds o_req_ready low.
module direct_mapped_cache_lookup_top #(
    parameter int INDEX_BITS = 14
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  dmcl_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output dmcl_pkg::t_rsp o_rsp
);
    import dmcl_pkg::*;

    localparam int TAG_BITS   = ADDR_BITS - OFFSET_BITS - INDEX_BITS;
    localparam int ENTRY_BITS = TAG_BITS + EPOCH_BITS;

    localparam logic ST_RUN   = 1'b0;
    localparam logic ST_SWEEP = 1'b1;

    logic                  r_state, n_state;
    logic [INDEX_BITS-1:0] r_sweep_idx;
    logic [EPOCH_BITS-1:0] r_epoch;

    logic                  r_s1_vld;
    t_req                  r_s1_req;

    logic                  r_fwd_vld;
    logic [INDEX_BITS-1:0] r_fwd_idx;
    logic [TAG_BITS-1:0]   r_fwd_tag;
    logic [WORD_BITS-1:0]  r_fwd_word;

    logic [COUNT_BITS-1:0] r_hits, n_hits;
    logic [COUNT_BITS-1:0] r_misses, n_misses;

    logic                  r_rsp_vld;
    t_rsp                  r_rsp, n_rsp;

    logic                  req_accept;
    logic                  sweeping;
    logic                  s1_adv;
    logic                  s1_is_read;
    logic                  s1_wrap_hold;
    logic [INDEX_BITS-1:0] req_idx;
    logic [INDEX_BITS-1:0] s1_idx;
    logic [TAG_BITS-1:0]   s1_tag;
    logic [OFFSET_BITS-1:0] s1_off;
    logic [ENTRY_BITS-1:0] ram_entry;
    logic [WORD_BITS-1:0]  ram_word;
    logic                  use_fwd;
    logic                  line_hit;
    logic [WORD_BITS-1:0]  line_word;
    logic                  miss_wr;
    logic                  inval_adv;
    logic                  tag_we;
    logic [INDEX_BITS-1:0] tag_waddr;
    logic [ENTRY_BITS-1:0] tag_wdata;

    // Field split of the incoming and the staged request
    assign req_idx = i_req.address[OFFSET_BITS +: INDEX_BITS];
    assign s1_idx  = r_s1_req.address[OFFSET_BITS +: INDEX_BITS];
    assign s1_tag  = r_s1_req.address[ADDR_BITS-1 -: TAG_BITS];
    assign s1_off  = r_s1_req.address[OFFSET_BITS-1:0];

    // Handshake and stage advance
    assign sweeping     = (r_state == ST_SWEEP);
    assign s1_adv       = r_s1_vld && (!r_rsp_vld || i_rsp_ready);
    assign s1_is_read   = (r_s1_req.kind == KIND_READ);
    assign s1_wrap_hold = r_s1_vld && !s1_is_read && (r_epoch == EPOCH_LAST);
    assign o_req_ready  = !sweeping && (!r_s1_vld || s1_adv) && !s1_wrap_hold;
    assign req_accept   = i_req_valid && o_req_ready;

    // Tag compare, with the line written in the same cycle as the read forwarded
    assign use_fwd  = r_fwd_vld && (r_fwd_idx == s1_idx);
    assign line_hit = s1_is_read &&
                      (use_fwd ? (r_fwd_tag == s1_tag)
                               : ((ram_entry[ENTRY_BITS-1 -: EPOCH_BITS] == r_epoch) &&
                                  (ram_entry[TAG_BITS-1:0] == s1_tag)));
    assign line_word = line_hit ? (use_fwd ? r_fwd_word : ram_word) : r_s1_req.fill_word;
    assign miss_wr   = s1_adv && s1_is_read && !line_hit;
    assign inval_adv = s1_adv && !s1_is_read;

    // Tag store port: sweep clears the epoch mark, a miss writes the new tag
    assign tag_we    = sweeping || miss_wr;
    assign tag_waddr = sweeping ? r_sweep_idx : s1_idx;
    assign tag_wdata = sweeping ? {EPOCH_NONE, {TAG_BITS{1'b0}}} : {r_epoch, s1_tag};

    dmcl_line_ram #(
        .ADDR_BITS (INDEX_BITS),
        .DATA_BITS (ENTRY_BITS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (tag_waddr),
        .i_wdata (tag_wdata),
        .i_re    (req_accept),
        .i_raddr (req_idx),
        .o_rdata (ram_entry)
    );

    dmcl_line_ram #(
        .ADDR_BITS (INDEX_BITS),
        .DATA_BITS (WORD_BITS)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (miss_wr),
        .i_waddr (s1_idx),
        .i_wdata (r_s1_req.fill_word),
        .i_re    (req_accept),
        .i_raddr (req_idx),
        .o_rdata (ram_word)
    );

    // Saturating counters, cleared by an invalidate, and the result word
    always_comb begin
        n_hits   = r_hits;
        n_misses = r_misses;
        n_rsp    = '0;
        if (s1_is_read) begin
            if (line_hit) begin
                n_hits = (r_hits == COUNT_MAX) ? r_hits : r_hits + 1'b1;
            end else begin
                n_misses = (r_misses == COUNT_MAX) ? r_misses : r_misses + 1'b1;
            end
            n_rsp.data_byte  = line_word[{s1_off, 3'b000} +: BYTE_BITS];
            n_rsp.was_hit    = line_hit;
            n_rsp.hit_total  = n_hits;
            n_rsp.miss_total = n_misses;
        end else begin
            n_hits   = '0;
            n_misses = '0;
        end
    end

    // Sweep sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_RUN: begin
                if (inval_adv && (r_epoch == EPOCH_LAST)) begin
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (&r_sweep_idx) begin
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_SWEEP;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SWEEP;
            r_sweep_idx <= '0;
            r_epoch     <= EPOCH_FIRST;
            r_s1_vld    <= 1'b0;
            r_fwd_vld   <= 1'b0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_rsp_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            // Advance the sweep pointer, restart it when a sweep begins
            if (sweeping) begin
                r_sweep_idx <= r_sweep_idx + 1'b1;
            end else begin
                r_sweep_idx <= '0;
            end
            // Bump the epoch on invalidate, restart it on wrap
            if (inval_adv) begin
                r_epoch <= (r_epoch == EPOCH_LAST) ? EPOCH_FIRST : r_epoch + 1'b1;
            end
            // Hold or advance the compare stage
            if (req_accept) begin
                r_s1_vld  <= 1'b1;
                r_fwd_vld <= miss_wr;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_hits   <= n_hits;
                r_misses <= n_misses;
            end
            // Hold the result until taken
            if (s1_adv) begin
                r_rsp_vld <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (req_accept) begin
            r_s1_req   <= i_req;
            r_fwd_idx  <= s1_idx;
            r_fwd_tag  <= s1_tag;
            r_fwd_word <= r_s1_req.fill_word;
        end
        if (s1_adv) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_vld;
    assign o_rsp       = r_rsp;

endmodule

/* sv/dmcl_line_ram.sv */
// Simple dual-port line store for the cache: one write and one registered read per cycle.
// A read at the address being written returns the old contents.
// No dependencies.
module dmcl_line_ram #(
    parameter int ADDR_BITS = 14,
    parameter int DATA_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [DATA_BITS-1:0] i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [DATA_BITS-1:0] o_rdata
);

    logic [DATA_BITS-1:0] r_mem [(2**ADDR_BITS)];
    logic [DATA_BITS-1:0] r_rdata;

    // Write on enable, capture read data on enable
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/dmcl_checker.sv */
// Port-level checker for the direct-mapped cache lookup top level, with its bind.
// Depends on dmcl_pkg and direct_mapped_cache_lookup_top.
module dmcl_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_rsp_valid,
    input logic           i_rsp_ready,
    input dmcl_pkg::t_rsp o_rsp
);
    import dmcl_pkg::*;

    // A stalled result holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !i_rsp_ready) |=> (o_rsp_valid && $stable(o_rsp)))
        else $error("result changed while stalled");

    // Reset drops the result
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid)
        else $error("result valid right after reset");

    // A hit follows its predecessor's counts by one hit
    a_hit_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && i_rsp_ready) ##1 (o_rsp_valid && i_rsp_ready && o_rsp.was_hit) |->
        ((o_rsp.miss_total == $past(o_rsp.miss_total)) &&
         ((o_rsp.hit_total == $past(o_rsp.hit_total) + 32'd1) ||
          ((o_rsp.hit_total == COUNT_MAX) && ($past(o_rsp.hit_total) == COUNT_MAX)))))
        else $error("hit count did not step by one");

    // A hit result always carries a nonzero hit count
    a_hit_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.was_hit) |-> (o_rsp.hit_total != '0))
        else $error("hit reported with zero hit count");

    // A result with no hit and no miss counted is an invalidate and reads as zero
    a_inval_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_rsp.was_hit && (o_rsp.miss_total == '0)) |->
        ((o_rsp.hit_total == '0) && (o_rsp.data_byte == '0)))
        else $error("invalidate result not cleared");

endmodule

bind direct_mapped_cache_lookup_top dmcl_checker u_dmcl_checker (.*);

/* test/testbench.sv */
`timescale 1ns / 100ps
// Testbench for direct_mapped_cache_lookup_top: directed and random reads and invalidates,
// each result checked against a line-by-line cache predictor. Depends on dmcl_pkg and the RTL.
module testbench;
    import dmcl_pkg::*;

    localparam int INDEX_BITS    = 14;
    localparam int TAG_BITS      = ADDR_BITS - OFFSET_BITS - INDEX_BITS;
    localparam int RANDOM_ITEMS  = 80;
    localparam int WRAP_ROUNDS   = 255;
    localparam int PRESSURE_HOLD = 250;
    localparam int DRAIN_CYCLES  = 10;
    localparam int STALL_LIMIT   = 60000;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_req_valid = 1'b0;
    logic o_req_ready;
    t_req i_req       = '0;
    logic o_rsp_valid;
    logic i_rsp_ready = 1'b0;
    t_rsp o_rsp;

    // Predicted cache contents; a line is valid while its index is present
    logic [TAG_BITS-1:0]   line_tag_q  [int];
    logic [WORD_BITS-1:0]  line_word_q [int];
    bit                    line_valid_q[int];
    logic [COUNT_BITS-1:0] hit_count  = '0;
    logic [COUNT_BITS-1:0] miss_count = '0;
    t_rsp                  pending_lookups[$];

    int error_count   = 0;
    int req_idle_pct  = 0;
    int rsp_idle_pct  = 0;
    bit pressure_req  = 1'b0;
    bit pressure_seen = 1'b0;
    int rsp_hold_left = 0;
    int idle_cycles   = 0;

    direct_mapped_cache_lookup_top #(
        .INDEX_BITS(INDEX_BITS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req_valid),
        .o_req_ready(o_req_ready),
        .i_req      (i_req),
        .o_rsp_valid(o_rsp_valid),
        .i_rsp_ready(i_rsp_ready),
        .o_rsp      (o_rsp)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [COUNT_BITS-1:0] count_up(input logic [COUNT_BITS-1:0] value);
        return (value == COUNT_MAX) ? value : value + 1'b1;
    endfunction

    // Apply one request to the predicted cache and return the result it must produce
    function automatic t_rsp cache_lookup(input t_req req);
        t_rsp                   rsp;
        int                     idx;
        logic [TAG_BITS-1:0]    tag;
        logic [OFFSET_BITS-1:0] ofs;
        rsp = '0;
        if (req.kind == KIND_INVAL) begin
            line_valid_q.delete();
            hit_count  = '0;
            miss_count = '0;
            return rsp;
        end
        ofs = req.address[OFFSET_BITS-1:0];
        idx = int'(req.address[OFFSET_BITS +: INDEX_BITS]);
        tag = req.address[ADDR_BITS-1 -: TAG_BITS];
        rsp.was_hit = line_valid_q.exists(idx) && (line_tag_q[idx] == tag);
        if (rsp.was_hit) begin
            hit_count = count_up(hit_count);
        end else begin
            line_tag_q[idx]   = tag;
            line_word_q[idx]  = req.fill_word;
            line_valid_q[idx] = 1'b1;
            miss_count = count_up(miss_count);
        end
        rsp.data_byte  = line_word_q[idx][ofs*BYTE_BITS +: BYTE_BITS];
        rsp.hit_total  = hit_count;
        rsp.miss_total = miss_count;
        return rsp;
    endfunction

    // Mostly no gap; when there is one, mostly short and now and then long
    function automatic int pick_gap(input int pct);
        if ($urandom_range(99) >= pct) return 0;
        if ($urandom_range(9) == 0) return $urandom_range(40, 8);
        return $urandom_range(3, 1);
    endfunction

    // Addresses drawn from a few tags and lines so that hits and evictions are frequent
    function automatic logic [ADDR_BITS-1:0] random_address();
        logic [TAG_BITS-1:0]   tag;
        logic [INDEX_BITS-1:0] idx;
        if ($urandom_range(3) == 0) return $urandom();
        case ($urandom_range(3))
            0: tag = '0;
            1: tag = '1;
            2: tag = TAG_BITS'('h5A3C);
            default: tag = TAG_BITS'($urandom());
        endcase
        case ($urandom_range(3))
            0: idx = '0;
            1: idx = '1;
            default: idx = INDEX_BITS'($urandom_range(15));
        endcase
        return {tag, idx, OFFSET_BITS'($urandom_range(3))};
    endfunction

    task automatic report_error(input string msg);
        $display("%0t ns: mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_error($sformatf("%s got %h want %h", name, got, want));
        end
    endtask

    // Offer one request after a random gap and hold it until it is taken
    task automatic send_request(input logic kind, input logic [ADDR_BITS-1:0] address,
                                input logic [WORD_BITS-1:0] fill_word);
        t_req req;
        int   gap;
        req.kind      = kind;
        req.address   = address;
        req.fill_word = fill_word;
        gap = pick_gap(req_idle_pct);
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= req;
        pending_lookups.push_back(cache_lookup(req));
        do begin
            @(posedge i_clk);
        end while (!o_req_ready);
    endtask

    // Result ready: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (pressure_req != pressure_seen) begin
            pressure_seen = pressure_req;
            rsp_hold_left = PRESSURE_HOLD;
        end
        if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            i_rsp_ready <= 1'b0;
        end else begin
            rsp_hold_left = pick_gap(rsp_idle_pct);
            i_rsp_ready <= (rsp_hold_left == 0);
            if (rsp_hold_left > 0) rsp_hold_left--;
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            if (pending_lookups.size() == 0) begin
                report_error($sformatf("unexpected result %h", o_rsp));
            end else begin
                want = pending_lookups.pop_front();
                check_field("data_byte", 32'(o_rsp.data_byte), 32'(want.data_byte));
                check_field("was_hit", 32'(o_rsp.was_hit), 32'(want.was_hit));
                check_field("hit_total", o_rsp.hit_total, want.hit_total);
                check_field("miss_total", o_rsp.miss_total, want.miss_total);
            end
        end
    end

    // Abort when no request or result moves for too long
    always @(posedge i_clk) begin
        if ((i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offsets, extreme tags and lines, conflicts and a read after invalidate
    task automatic test_directed_lookup();
        req_idle_pct = 20;
        rsp_idle_pct = 20;
        send_request(KIND_READ, 32'h0000_0000, 32'h1122_3344);   // cold miss, byte 0
        send_request(KIND_READ, 32'h0000_0003, 32'hDEAD_BEEF);   // hit, fill ignored
        send_request(KIND_READ, 32'h0000_0001, 32'h0000_0000);
        send_request(KIND_READ, 32'h0000_0002, 32'hFFFF_FFFF);
        send_request(KIND_READ, 32'hFFFF_FFFF, 32'hA5C3_0FF0);   // top tag, top line
        send_request(KIND_READ, 32'hFFFF_FFFC, 32'h0000_0000);
        send_request(KIND_READ, 32'h0000_FFFC, 32'h0F0F_F0F0);   // evict top line
        send_request(KIND_READ, 32'hFFFF_FFFD, 32'h7E81_18E7);   // evict it back
        send_request(KIND_READ, 32'hFFFF_0000, 32'hFFFF_FFFF);   // evict line zero
        send_request(KIND_READ, 32'h0000_0000, 32'h0000_0000);
        send_request(KIND_READ, 32'hFFFF_0001, 32'hC3C3_3C3C);
        send_request(KIND_INVAL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(KIND_READ, 32'hFFFF_FFFF, 32'h1234_5678);   // miss after invalidate
        send_request(KIND_READ, 32'hFFFF_FFFE, 32'h0000_0000);
        send_request(KIND_READ, 32'hAAAA_5555, 32'h5555_AAAA);
        send_request(KIND_READ, 32'h5555_AAAA, 32'hAAAA_5555);
        send_request(KIND_READ, 32'hAAAA_5554, 32'h0000_0000);
        send_request(KIND_INVAL, 32'h0000_0000, 32'h0000_0000);
        send_request(KIND_READ, 32'hAAAA_5555, 32'h9696_6969);
        send_request(KIND_READ, 32'h0000_0000, 32'h0102_0304);
    endtask

    // Hold results back for a long stretch while requests keep coming
    task automatic test_result_backpressure();
        req_idle_pct = 0;
        rsp_idle_pct = 0;
        pressure_req <= ~pressure_req;
        repeat (40) send_request(KIND_READ, random_address(), $urandom());
    endtask

    // Random reads with rare invalidates, idle rates changing between stretches
    task automatic test_random_traffic();
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) begin
                req_idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(60, 10);
                rsp_idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(60, 10);
            end
            if ($urandom_range(39) == 0) begin
                send_request(KIND_INVAL, $urandom(), $urandom());
            end else begin
                send_request(KIND_READ, random_address(), $urandom());
            end
        end
    endtask

    // Fill a line, run one full epoch cycle of invalidates, then read the line again:
    // the epoch is back where the line was filled, so a line left from the fill would match again but for the sweep
    task automatic test_epoch_wrap();
        logic [ADDR_BITS-1:0] address;
        req_idle_pct = 5;
        rsp_idle_pct = 5;
        address = random_address();
        send_request(KIND_READ, address, $urandom());
        for (int n = 0; n < WRAP_ROUNDS; n++) begin
            send_request(KIND_INVAL, $urandom(), $urandom());
            if (n % 32 == 31) send_request(KIND_READ, random_address(), $urandom());
        end
        send_request(KIND_READ, address, $urandom());
        send_request(KIND_READ, address ^ 32'h3, $urandom());
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_lookup();
        test_result_backpressure();
        test_random_traffic();
        test_epoch_wrap();
        i_req_valid <= 1'b0;
        // drain, then allow stray results to show up
        while (pending_lookups.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
